// ===== hdl/vector_path_record_decoder_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Vector path record decoder - assertion macros
// Shared property wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VECTOR_PATH_RECORD_DECODER_UNIT_DEFINES_SVH
`define VECTOR_PATH_RECORD_DECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define VPR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VPR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/vpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Vector path record decoder - package
// Record selectors, result kinds, warning codes, register indexes and the
// coordinate scaling function.
// ----------------------------------------------------------------------------
package vpr_pkg;

  localparam int unsigned SEL_W   = 16;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned DIM_W   = 19;
  localparam int unsigned COORD_W = 51;
  localparam int unsigned IDX_W   = 28;
  localparam int unsigned KNOT_W  = 28;
  localparam int unsigned DECL_W  = 16;
  localparam int unsigned OP_W    = 16;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_DOC_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOC_HEIGHT = 8'd1;

  localparam logic [SEL_W-1:0] SEL_CLOSED_LEN    = 16'd0;
  localparam logic [SEL_W-1:0] SEL_CLOSED_SMOOTH = 16'd1;
  localparam logic [SEL_W-1:0] SEL_CLOSED_CORNER = 16'd2;
  localparam logic [SEL_W-1:0] SEL_OPEN_LEN      = 16'd3;
  localparam logic [SEL_W-1:0] SEL_OPEN_SMOOTH   = 16'd4;
  localparam logic [SEL_W-1:0] SEL_OPEN_CORNER   = 16'd5;
  localparam logic [SEL_W-1:0] SEL_PATH_FILL     = 16'd6;
  localparam logic [SEL_W-1:0] SEL_CLIPBOARD     = 16'd7;
  localparam logic [SEL_W-1:0] SEL_INIT_FILL     = 16'd8;

  localparam logic [OP_W-1:0] OP_MAX_KNOWN = 16'd3;
  localparam logic [OP_W-1:0] OP_MINUS_ONE = 16'hFFFF;

  localparam logic [DIM_W-1:0] DIM_RESET = 19'd1;

  typedef enum logic [2:0] {
    KIND_ANCHOR      = 3'd0,
    KIND_END_KNOWN   = 3'd1,
    KIND_END_UNKNOWN = 3'd2,
    KIND_WARNING     = 3'd3,
    KIND_BLOCK_END   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    WARN_NONE       = 3'd0,
    WARN_COUNT      = 3'd1,
    WARN_UNKNOWN_OP = 3'd2,
    WARN_IMPLICIT   = 3'd3,
    WARN_CLIPBOARD  = 3'd4,
    WARN_UNKNOWN_SEL = 3'd5
  } warn_e;

  typedef struct packed {
    logic                     opcode;
    logic [SEL_W-1:0]         selector;
    logic signed [WORD_W-1:0] word_in_y;
    logic signed [WORD_W-1:0] word_in_x;
    logic signed [WORD_W-1:0] word_pt_y;
    logic signed [WORD_W-1:0] word_pt_x;
    logic signed [WORD_W-1:0] word_out_y;
    logic signed [WORD_W-1:0] word_out_x;
  } rec_t;

  typedef struct packed {
    kind_e                     kind;
    logic [IDX_W-1:0]          record_index;
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] pt_x;
    logic signed [COORD_W-1:0] pt_y;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      flag_bit;
    logic signed [OP_W-1:0]    path_op;
    logic [KNOT_W-1:0]         knot_count;
    warn_e                     warn_code;
  } res_t;

  // signed 8.24 word times document size, exact in 51 bits
  function automatic logic signed [COORD_W-1:0] scale_coord(
    input logic signed [WORD_W-1:0] w,
    input logic [DIM_W-1:0]         d
  );
    logic signed [DIM_W:0]          ds;
    logic signed [WORD_W+DIM_W:0]   p;
    ds = signed'({1'b0, d});
    p  = w * ds;
    return p[COORD_W-1:0];
  endfunction

endpackage

// ===== hdl/vpr_rec_if.sv =====
// ----------------------------------------------------------------------------
// Vector path record decoder - record channel
// One path record or end-of-block item per handshake.
// ----------------------------------------------------------------------------
interface vpr_rec_if;
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [15:0]             selector;
  logic signed [31:0]      word_in_y;
  logic signed [31:0]      word_in_x;
  logic signed [31:0]      word_pt_y;
  logic signed [31:0]      word_pt_x;
  logic signed [31:0]      word_out_y;
  logic signed [31:0]      word_out_x;

  modport source (
    output valid, opcode, selector, word_in_y, word_in_x, word_pt_y, word_pt_x,
           word_out_y, word_out_x,
    input  ready
  );
  modport sink (
    input  valid, opcode, selector, word_in_y, word_in_x, word_pt_y, word_pt_x,
           word_out_y, word_out_x,
    output ready
  );
endinterface

// ===== hdl/vpr_res_if.sv =====
// ----------------------------------------------------------------------------
// Vector path record decoder - result channel
// One anchor, subpath end, warning or block end per handshake.
// ----------------------------------------------------------------------------
interface vpr_res_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [27:0]        record_index;
  logic signed [50:0] in_x;
  logic signed [50:0] in_y;
  logic signed [50:0] pt_x;
  logic signed [50:0] pt_y;
  logic signed [50:0] out_x;
  logic signed [50:0] out_y;
  logic               flag_bit;
  logic signed [15:0] path_op;
  logic [27:0]        knot_count;
  logic [2:0]         warn_code;

  modport source (
    output valid, kind, record_index, in_x, in_y, pt_x, pt_y, out_x, out_y,
           flag_bit, path_op, knot_count, warn_code,
    input  ready
  );
  modport sink (
    input  valid, kind, record_index, in_x, in_y, pt_x, pt_y, out_x, out_y,
           flag_bit, path_op, knot_count, warn_code,
    output ready
  );
endinterface

// ===== hdl/vpr_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Vector path record decoder - configuration write channel
// Register index and write data per handshake.
// ----------------------------------------------------------------------------
interface vpr_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [18:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/vector_path_record_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// Vector path record decoder - top level
// Groups knot records into subpaths, scales knot coordinates by the document
// size and reports anchors, subpath ends, warnings and block ends.
// ----------------------------------------------------------------------------
//  channel  | modport | carries
//  ---------+---------+---------------------------------------------------
//  rec_i    | sink    | path record or end of block, one item per handshake
//  res_o    | source  | result item, up to three per record
//  cfg_i    | sink    | doc_width (0) / doc_height (1) writes, always ready
//
//  Records are held in an input register, decoded and scaled (six 32x19
//  multiplies) into a three-entry result buffer, then read out one result
//  per cycle while res_o is ready. The next record loads when the buffer is
//  empty or in the same cycle as its last result is taken. Back-pressure on
//  res_o stalls the buffer and then rec_i. Reset clears the subpath and
//  counter state but sets the path op to 1 (known); both document sizes go to 1.
// ----------------------------------------------------------------------------
module vector_path_record_decoder_unit #(
  parameter int unsigned INDEX_BITS = 28
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vpr_rec_if.sink    rec_i,
  vpr_res_if.source  res_o,
  vpr_cfg_if.sink    cfg_i
);

  localparam int unsigned SLOTS = 3;

  // configuration
  logic [vpr_pkg::DIM_W-1:0] width_q, height_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= vpr_pkg::DIM_RESET;
      height_q <= vpr_pkg::DIM_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == vpr_pkg::CFG_DOC_WIDTH) begin
        width_q <= cfg_i.data;
      end
      if (cfg_i.index == vpr_pkg::CFG_DOC_HEIGHT) begin
        height_q <= cfg_i.data;
      end
    end
  end

  // input register
  vpr_pkg::rec_t hold_q;
  logic          hold_valid_q;
  logic          load;
  logic          rec_acc;

  assign rec_i.ready = !hold_valid_q || load;
  assign rec_acc     = rec_i.valid && rec_i.ready;

  always_ff @(posedge clk_i) begin
    if (rec_acc) begin
      hold_q <= '{opcode:     rec_i.opcode,
                  selector:   rec_i.selector,
                  word_in_y:  rec_i.word_in_y,
                  word_in_x:  rec_i.word_in_x,
                  word_pt_y:  rec_i.word_pt_y,
                  word_pt_x:  rec_i.word_pt_x,
                  word_out_y: rec_i.word_out_y,
                  word_out_x: rec_i.word_out_x};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (rec_acc) begin
      hold_valid_q <= 1'b1;
    end else if (load) begin
      hold_valid_q <= 1'b0;
    end
  end

  // subpath state
  logic                       pend_q, pend_d;
  logic                       closed_q, closed_d;
  logic [vpr_pkg::OP_W-1:0]   op_q, op_d;
  logic                       known_q, known_d;
  logic [vpr_pkg::DECL_W-1:0] decl_q, decl_d;
  logic [vpr_pkg::KNOT_W-1:0] present_q, present_d;
  logic [INDEX_BITS-1:0]      rec_cnt_q, rec_cnt_d;
  logic                       open_seen_q, open_seen_d;

  // result buffer
  vpr_pkg::res_t slots_q [SLOTS];
  vpr_pkg::res_t slots_d [SLOTS];
  logic [1:0]    cnt_q, cnt_d;
  logic [1:0]    rd_ptr_q;
  logic          pop, last;

  logic [31:0]                 cnt_wide;
  logic [vpr_pkg::IDX_W-1:0]   rec_idx;
  logic [vpr_pkg::SEL_W-1:0]   sel;
  logic [vpr_pkg::OP_W-1:0]    op_w;
  logic                        op_known;
  logic                        is_len, is_knot, knot_closed, knot_smooth;
  logic                        do_flush;
  vpr_pkg::res_t               base;

  assign cnt_wide = 32'(rec_cnt_q);
  assign rec_idx  = cnt_wide[vpr_pkg::IDX_W-1:0];
  assign sel      = hold_q.selector;
  assign op_w     = hold_q.word_in_y[vpr_pkg::OP_W-1:0];
  assign op_known = (op_w <= vpr_pkg::OP_MAX_KNOWN) || (op_w == vpr_pkg::OP_MINUS_ONE);
  assign is_len   = (sel == vpr_pkg::SEL_CLOSED_LEN) || (sel == vpr_pkg::SEL_OPEN_LEN);
  assign knot_closed = (sel == vpr_pkg::SEL_CLOSED_SMOOTH) ||
                       (sel == vpr_pkg::SEL_CLOSED_CORNER);
  assign knot_smooth = (sel == vpr_pkg::SEL_CLOSED_SMOOTH) ||
                       (sel == vpr_pkg::SEL_OPEN_SMOOTH);
  assign is_knot  = knot_closed || (sel == vpr_pkg::SEL_OPEN_SMOOTH) ||
                    (sel == vpr_pkg::SEL_OPEN_CORNER);
  assign do_flush = pend_q && (hold_q.opcode || !is_knot);

  always_comb begin
    base              = '0;
    base.kind         = vpr_pkg::KIND_WARNING;
    base.warn_code    = vpr_pkg::WARN_NONE;
    base.record_index = rec_idx;

    slots_d     = '{default: '0};
    cnt_d       = 2'd0;
    pend_d      = pend_q;
    closed_d    = closed_q;
    op_d        = op_q;
    known_d     = known_q;
    decl_d      = decl_q;
    present_d   = present_q;
    rec_cnt_d   = rec_cnt_q;
    open_seen_d = open_seen_q;

    if (do_flush) begin
      if (present_q != vpr_pkg::KNOT_W'(decl_q)) begin
        slots_d[cnt_d]            = base;
        slots_d[cnt_d].warn_code  = vpr_pkg::WARN_COUNT;
        slots_d[cnt_d].knot_count = present_q;
        cnt_d                     = cnt_d + 2'd1;
      end
      slots_d[cnt_d]            = base;
      slots_d[cnt_d].kind       = known_q ? vpr_pkg::KIND_END_KNOWN
                                          : vpr_pkg::KIND_END_UNKNOWN;
      slots_d[cnt_d].flag_bit   = closed_q;
      slots_d[cnt_d].path_op    = op_q;
      slots_d[cnt_d].knot_count = present_q;
      cnt_d                     = cnt_d + 2'd1;
      pend_d                    = 1'b0;
    end

    if (hold_q.opcode) begin
      slots_d[cnt_d]          = base;
      slots_d[cnt_d].kind     = vpr_pkg::KIND_BLOCK_END;
      slots_d[cnt_d].flag_bit = open_seen_q;
      cnt_d                   = cnt_d + 2'd1;
      rec_cnt_d               = '0;
      open_seen_d             = 1'b0;
    end else begin
      if (is_len) begin
        pend_d    = 1'b1;
        closed_d  = (sel == vpr_pkg::SEL_CLOSED_LEN);
        op_d      = op_w;
        known_d   = op_known;
        decl_d    = hold_q.word_in_y[vpr_pkg::WORD_W-1:vpr_pkg::OP_W];
        present_d = '0;
        if (sel == vpr_pkg::SEL_OPEN_LEN) begin
          open_seen_d = 1'b1;
        end
        if (!op_known) begin
          slots_d[cnt_d]           = base;
          slots_d[cnt_d].warn_code = vpr_pkg::WARN_UNKNOWN_OP;
          slots_d[cnt_d].path_op   = op_w;
          cnt_d                    = cnt_d + 2'd1;
        end
      end else if (is_knot) begin
        if (!pend_q) begin
          slots_d[cnt_d]           = base;
          slots_d[cnt_d].warn_code = vpr_pkg::WARN_IMPLICIT;
          cnt_d                    = cnt_d + 2'd1;
          pend_d                   = 1'b1;
          closed_d                 = knot_closed;
          op_d                     = '0;
          known_d                  = 1'b0;
          decl_d                   = '0;
          present_d                = vpr_pkg::KNOT_W'(1);
        end else if (present_q != '1) begin
          present_d = present_q + vpr_pkg::KNOT_W'(1);
        end
        slots_d[cnt_d]          = base;
        slots_d[cnt_d].kind     = vpr_pkg::KIND_ANCHOR;
        slots_d[cnt_d].in_x     = vpr_pkg::scale_coord(hold_q.word_in_x, width_q);
        slots_d[cnt_d].in_y     = vpr_pkg::scale_coord(hold_q.word_in_y, height_q);
        slots_d[cnt_d].pt_x     = vpr_pkg::scale_coord(hold_q.word_pt_x, width_q);
        slots_d[cnt_d].pt_y     = vpr_pkg::scale_coord(hold_q.word_pt_y, height_q);
        slots_d[cnt_d].out_x    = vpr_pkg::scale_coord(hold_q.word_out_x, width_q);
        slots_d[cnt_d].out_y    = vpr_pkg::scale_coord(hold_q.word_out_y, height_q);
        slots_d[cnt_d].flag_bit = knot_smooth;
        cnt_d                   = cnt_d + 2'd1;
      end else if ((sel == vpr_pkg::SEL_PATH_FILL) || (sel == vpr_pkg::SEL_INIT_FILL)) begin
        cnt_d = cnt_d;
      end else begin
        slots_d[cnt_d]           = base;
        slots_d[cnt_d].warn_code = (sel == vpr_pkg::SEL_CLIPBOARD)
                                   ? vpr_pkg::WARN_CLIPBOARD : vpr_pkg::WARN_UNKNOWN_SEL;
        cnt_d                    = cnt_d + 2'd1;
      end
      if (rec_cnt_q != '1) begin
        rec_cnt_d = rec_cnt_q + INDEX_BITS'(1);
      end
    end
  end

  // buffer control
  assign pop  = res_o.valid && res_o.ready;
  assign last = (rd_ptr_q + 2'd1) == cnt_q;
  assign load = hold_valid_q && ((cnt_q == 2'd0) || (pop && last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      closed_q    <= 1'b0;
      op_q        <= vpr_pkg::OP_W'(1);
      known_q     <= 1'b1;
      decl_q      <= '0;
      present_q   <= '0;
      rec_cnt_q   <= '0;
      open_seen_q <= 1'b0;
      cnt_q       <= 2'd0;
      rd_ptr_q    <= 2'd0;
    end else if (load) begin
      pend_q      <= pend_d;
      closed_q    <= closed_d;
      op_q        <= op_d;
      known_q     <= known_d;
      decl_q      <= decl_d;
      present_q   <= present_d;
      rec_cnt_q   <= rec_cnt_d;
      open_seen_q <= open_seen_d;
      cnt_q       <= cnt_d;
      rd_ptr_q    <= 2'd0;
    end else if (pop) begin
      if (last) begin
        cnt_q    <= 2'd0;
        rd_ptr_q <= 2'd0;
      end else begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      slots_q <= slots_d;
    end
  end

  vpr_pkg::res_t cur;
  assign cur = slots_q[rd_ptr_q];

  assign res_o.valid        = (cnt_q != 2'd0);
  assign res_o.kind         = cur.kind;
  assign res_o.record_index = cur.record_index;
  assign res_o.in_x         = cur.in_x;
  assign res_o.in_y         = cur.in_y;
  assign res_o.pt_x         = cur.pt_x;
  assign res_o.pt_y         = cur.pt_y;
  assign res_o.out_x        = cur.out_x;
  assign res_o.out_y        = cur.out_y;
  assign res_o.flag_bit     = cur.flag_bit;
  assign res_o.path_op      = cur.path_op;
  assign res_o.knot_count   = cur.knot_count;
  assign res_o.warn_code    = cur.warn_code;

endmodule

// ===== hdl/vpr_checker.sv =====
// ----------------------------------------------------------------------------
// Vector path record decoder - port checker
// Checks that kind and warning code hold under stall, and field consistency per result kind.
// ----------------------------------------------------------------------------
`include "vector_path_record_decoder_unit_defines.svh"

module vpr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input logic [2:0]         kind_i,
  input logic [2:0]         warn_code_i,
  input logic signed [15:0] path_op_i,
  input logic signed [50:0] pt_x_i,
  input logic signed [50:0] pt_y_i
);

  `VPR_ASSERT_NXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(kind_i) && $stable(warn_code_i), "result changed while stalled")
  `VPR_ASSERT_IMP(a_anchor_clean, res_valid_i && (kind_i == vpr_pkg::KIND_ANCHOR), (warn_code_i == vpr_pkg::WARN_NONE) && (path_op_i == 16'sd0), "anchor carries warning or op")
  `VPR_ASSERT_IMP(a_warn_code, res_valid_i && (kind_i == vpr_pkg::KIND_WARNING), (warn_code_i != vpr_pkg::WARN_NONE) && (warn_code_i <= vpr_pkg::WARN_UNKNOWN_SEL), "warning without valid code")
  `VPR_ASSERT_IMP(a_coord_zero, res_valid_i && (kind_i != vpr_pkg::KIND_ANCHOR), (pt_x_i == 51'sd0) && (pt_y_i == 51'sd0) && (kind_i <= vpr_pkg::KIND_BLOCK_END), "non-anchor with coordinates")

endmodule

bind vector_path_record_decoder_unit vpr_checker u_vpr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .kind_i      (res_o.kind),
  .warn_code_i (res_o.warn_code),
  .path_op_i   (res_o.path_op),
  .pt_x_i      (res_o.pt_x),
  .pt_y_i      (res_o.pt_y)
);

// ===== tb/sv/tb_vpr_decode_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vector path record decoder - result checker
// Watches the record, result and configuration channels, decodes every
// accepted record into the result items it must produce and compares each
// accepted result item, field by field, with the oldest one still queued.
// ----------------------------------------------------------------------------
module tb_vpr_decode_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  vpr_rec_if          rec_i,
  vpr_res_if          res_i,
  vpr_cfg_if          cfg_i,
  output int unsigned mismatches_o,
  output int unsigned outstanding_o
);

  logic [vpr_pkg::DIM_W-1:0]  doc_w;
  logic [vpr_pkg::DIM_W-1:0]  doc_h;
  logic                       subpath_open;
  logic                       subpath_closed;
  logic [vpr_pkg::OP_W-1:0]   subpath_op;
  logic                       subpath_op_known;
  logic [vpr_pkg::DECL_W-1:0] knots_declared;
  logic [vpr_pkg::KNOT_W-1:0] knots_seen;
  logic [vpr_pkg::IDX_W-1:0]  record_count;
  logic                       open_len_seen;

  vpr_pkg::res_t decoded_q[$];
  int unsigned   mismatches = 0;
  int unsigned   queued = 0;

  assign mismatches_o  = mismatches;
  assign outstanding_o = queued;

  function automatic logic signed [vpr_pkg::COORD_W-1:0] to_pixels(
    input logic signed [vpr_pkg::WORD_W-1:0] w,
    input logic [vpr_pkg::DIM_W-1:0]         d
  );
    longint prod;
    prod = longint'(w) * longint'({1'b0, d});
    return prod[vpr_pkg::COORD_W-1:0];
  endfunction

  function automatic void queue_result(input vpr_pkg::res_t r);
    decoded_q.insert(decoded_q.size(), r);
  endfunction

  function automatic vpr_pkg::res_t blank_result(input vpr_pkg::kind_e k,
                                                 input vpr_pkg::warn_e w);
    vpr_pkg::res_t r;
    r = '0;
    r.kind = k;
    r.record_index = record_count;
    r.warn_code = w;
    return r;
  endfunction

  function automatic void close_subpath();
    vpr_pkg::res_t r;
    if (!subpath_open) return;
    if (knots_seen != knots_declared) begin
      r = blank_result(vpr_pkg::KIND_WARNING, vpr_pkg::WARN_COUNT);
      r.knot_count = knots_seen;
      queue_result(r);
    end
    if (subpath_op_known) r = blank_result(vpr_pkg::KIND_END_KNOWN, vpr_pkg::WARN_NONE);
    else r = blank_result(vpr_pkg::KIND_END_UNKNOWN, vpr_pkg::WARN_NONE);
    r.flag_bit = subpath_closed;
    r.path_op = subpath_op;
    r.knot_count = knots_seen;
    queue_result(r);
    subpath_open = 1'b0;
  endfunction

  function automatic void decode_record(input vpr_pkg::rec_t item);
    vpr_pkg::res_t            r;
    logic [vpr_pkg::OP_W-1:0] op;
    logic                     known;
    logic                     closed;
    if (item.opcode) begin
      close_subpath();
      r = blank_result(vpr_pkg::KIND_BLOCK_END, vpr_pkg::WARN_NONE);
      r.flag_bit = open_len_seen;
      queue_result(r);
      record_count = '0;
      open_len_seen = 1'b0;
      return;
    end
    case (item.selector)
      vpr_pkg::SEL_CLOSED_LEN, vpr_pkg::SEL_OPEN_LEN: begin
        op = item.word_in_y[vpr_pkg::OP_W-1:0];
        known = (op <= vpr_pkg::OP_MAX_KNOWN) || (op == vpr_pkg::OP_MINUS_ONE);
        close_subpath();
        subpath_open = 1'b1;
        subpath_closed = (item.selector == vpr_pkg::SEL_CLOSED_LEN);
        subpath_op = op;
        subpath_op_known = known;
        knots_declared = item.word_in_y[vpr_pkg::WORD_W-1:vpr_pkg::OP_W];
        knots_seen = '0;
        if (item.selector == vpr_pkg::SEL_OPEN_LEN) open_len_seen = 1'b1;
        if (!known) begin
          r = blank_result(vpr_pkg::KIND_WARNING, vpr_pkg::WARN_UNKNOWN_OP);
          r.path_op = op;
          queue_result(r);
        end
      end
      vpr_pkg::SEL_CLOSED_SMOOTH, vpr_pkg::SEL_CLOSED_CORNER,
      vpr_pkg::SEL_OPEN_SMOOTH, vpr_pkg::SEL_OPEN_CORNER: begin
        closed = (item.selector == vpr_pkg::SEL_CLOSED_SMOOTH) ||
                 (item.selector == vpr_pkg::SEL_CLOSED_CORNER);
        if (!subpath_open) begin
          queue_result(blank_result(vpr_pkg::KIND_WARNING, vpr_pkg::WARN_IMPLICIT));
          subpath_open = 1'b1;
          subpath_closed = closed;
          subpath_op = '0;
          subpath_op_known = 1'b0;
          knots_declared = '0;
          knots_seen = '0;
        end
        r = blank_result(vpr_pkg::KIND_ANCHOR, vpr_pkg::WARN_NONE);
        r.in_x  = to_pixels(item.word_in_x, doc_w);
        r.in_y  = to_pixels(item.word_in_y, doc_h);
        r.pt_x  = to_pixels(item.word_pt_x, doc_w);
        r.pt_y  = to_pixels(item.word_pt_y, doc_h);
        r.out_x = to_pixels(item.word_out_x, doc_w);
        r.out_y = to_pixels(item.word_out_y, doc_h);
        r.flag_bit = (item.selector == vpr_pkg::SEL_CLOSED_SMOOTH) ||
                     (item.selector == vpr_pkg::SEL_OPEN_SMOOTH);
        queue_result(r);
        if (knots_seen != '1) knots_seen = knots_seen + 1'b1;
      end
      vpr_pkg::SEL_PATH_FILL, vpr_pkg::SEL_INIT_FILL: begin
        close_subpath();
      end
      vpr_pkg::SEL_CLIPBOARD: begin
        close_subpath();
        queue_result(blank_result(vpr_pkg::KIND_WARNING, vpr_pkg::WARN_CLIPBOARD));
      end
      default: begin
        close_subpath();
        queue_result(blank_result(vpr_pkg::KIND_WARNING, vpr_pkg::WARN_UNKNOWN_SEL));
      end
    endcase
    if (record_count != '1) record_count = record_count + 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_result();
    vpr_pkg::res_t want;
    if (decoded_q.size() == 0) begin
      $error("result item with none queued: kind %0d, record_index %0d",
             res_i.kind, res_i.record_index);
      mismatches++;
    end else begin
      want = decoded_q.pop_front();
      check_field("kind", want.kind, res_i.kind);
      check_field("record_index", want.record_index, res_i.record_index);
      check_field("in_x", want.in_x, res_i.in_x);
      check_field("in_y", want.in_y, res_i.in_y);
      check_field("pt_x", want.pt_x, res_i.pt_x);
      check_field("pt_y", want.pt_y, res_i.pt_y);
      check_field("out_x", want.out_x, res_i.out_x);
      check_field("out_y", want.out_y, res_i.out_y);
      check_field("flag_bit", want.flag_bit, res_i.flag_bit);
      check_field("path_op", want.path_op, res_i.path_op);
      check_field("knot_count", want.knot_count, res_i.knot_count);
      check_field("warn_code", want.warn_code, res_i.warn_code);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    vpr_pkg::rec_t item;
    if (!rst_ni) begin
      doc_w = vpr_pkg::DIM_RESET;
      doc_h = vpr_pkg::DIM_RESET;
      subpath_open = 1'b0;
      subpath_closed = 1'b0;
      subpath_op = vpr_pkg::OP_W'(1);
      subpath_op_known = 1'b1;
      knots_declared = '0;
      knots_seen = '0;
      record_count = '0;
      open_len_seen = 1'b0;
      decoded_q.delete();
    end else begin
      // results of a record accepted on this edge cannot be out yet
      if (res_i.valid && res_i.ready) compare_result();
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == vpr_pkg::CFG_DOC_WIDTH) doc_w = cfg_i.data;
        else if (cfg_i.index == vpr_pkg::CFG_DOC_HEIGHT) doc_h = cfg_i.data;
      end
      if (rec_i.valid && rec_i.ready) begin
        item.opcode     = rec_i.opcode;
        item.selector   = rec_i.selector;
        item.word_in_y  = rec_i.word_in_y;
        item.word_in_x  = rec_i.word_in_x;
        item.word_pt_y  = rec_i.word_pt_y;
        item.word_pt_x  = rec_i.word_pt_x;
        item.word_out_y = rec_i.word_out_y;
        item.word_out_x = rec_i.word_out_x;
        decode_record(item);
      end
    end
    queued = decoded_q.size();
  end

endmodule

// ===== tb/sv/tb_vector_path_record_decoder_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vector path record decoder - testbench top
// Drives directed and random path records through the decoder under random
// idling on both sides, changes the document size between phases and gives
// the verdict from the result checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module tb_vector_path_record_decoder_unit;

  localparam logic        OPC_RECORD      = 1'b0;
  localparam logic        OPC_BLOCK_END   = 1'b1;
  localparam int unsigned DOC_MAX         = 300000;
  localparam int unsigned IDLE_PCT        = 32;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned PHASE_ITEMS     = 70;

  logic clk_i;
  logic rst_ni;

  vpr_rec_if rec_ch ();
  vpr_res_if res_ch ();
  vpr_cfg_if cfg_ch ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned send_idle_pct = IDLE_PCT;
  int unsigned recv_idle_pct = IDLE_PCT;
  logic        hold_off_req = 1'b0;

  vector_path_record_decoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rec_i  (rec_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  tb_vpr_decode_checker u_decode_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_i         (rec_ch),
    .res_i         (res_ch),
    .cfg_i         (cfg_ch),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("tb_vector_path_record_decoder_unit: done, errors");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin : res_drive
    int unsigned hold;
    hold = 0;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = HOLD_OFF_CYCLES;
      end
      if (hold > 0) begin
        res_ch.ready <= 1'b0;
        hold--;
      end else begin
        res_ch.ready <= !($urandom_range(99) < recv_idle_pct);
      end
      @(posedge clk_i);
    end
  end

  function automatic logic signed [vpr_pkg::WORD_W-1:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return {1'b1, {(vpr_pkg::WORD_W-1){1'b0}}};
    if (pick == 1) return {1'b0, {(vpr_pkg::WORD_W-1){1'b1}}};
    if (pick == 2) return '0;
    if (pick == 3) return '1;
    return $urandom;
  endfunction

  function automatic vpr_pkg::rec_t record_item(input logic [vpr_pkg::SEL_W-1:0] sel);
    vpr_pkg::rec_t r;
    r.opcode     = OPC_RECORD;
    r.selector   = sel;
    r.word_in_y  = rand_word();
    r.word_in_x  = rand_word();
    r.word_pt_y  = rand_word();
    r.word_pt_x  = rand_word();
    r.word_out_y = rand_word();
    r.word_out_x = rand_word();
    return r;
  endfunction

  function automatic vpr_pkg::rec_t length_item(input logic [vpr_pkg::SEL_W-1:0] sel,
                                                input logic [vpr_pkg::DECL_W-1:0] count,
                                                input logic [vpr_pkg::OP_W-1:0] op);
    vpr_pkg::rec_t r;
    r = record_item(sel);
    r.word_in_y = {count, op};
    return r;
  endfunction

  function automatic vpr_pkg::rec_t flat_knot(input logic [vpr_pkg::SEL_W-1:0] sel,
                                              input logic signed [vpr_pkg::WORD_W-1:0] v);
    vpr_pkg::rec_t r;
    r = record_item(sel);
    r.word_in_y  = v;
    r.word_in_x  = v;
    r.word_pt_y  = v;
    r.word_pt_x  = v;
    r.word_out_y = v;
    r.word_out_x = v;
    return r;
  endfunction

  function automatic vpr_pkg::rec_t block_end_item();
    vpr_pkg::rec_t r;
    r = record_item(vpr_pkg::SEL_W'($urandom));
    r.opcode = OPC_BLOCK_END;
    return r;
  endfunction

  function automatic logic [vpr_pkg::OP_W-1:0] known_op();
    int unsigned v;
    v = $urandom_range(vpr_pkg::OP_MAX_KNOWN + 1);
    if (v > vpr_pkg::OP_MAX_KNOWN) return vpr_pkg::OP_MINUS_ONE;
    return vpr_pkg::OP_W'(v);
  endfunction

  task automatic send_item(input vpr_pkg::rec_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      rec_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    rec_ch.valid      <= 1'b1;
    rec_ch.opcode     <= r.opcode;
    rec_ch.selector   <= r.selector;
    rec_ch.word_in_y  <= r.word_in_y;
    rec_ch.word_in_x  <= r.word_in_x;
    rec_ch.word_pt_y  <= r.word_pt_y;
    rec_ch.word_pt_x  <= r.word_pt_x;
    rec_ch.word_out_y <= r.word_out_y;
    rec_ch.word_out_x <= r.word_out_x;
    @(posedge clk_i);
    while (!rec_ch.ready) @(posedge clk_i);
  endtask

  task automatic drain_results();
    rec_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // both sizes, then a write to an unused index that must change nothing
  task automatic set_doc_size(input logic [vpr_pkg::DIM_W-1:0] w,
                              input logic [vpr_pkg::DIM_W-1:0] h);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= vpr_pkg::CFG_DOC_WIDTH;
    cfg_ch.data  <= w;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.index <= vpr_pkg::CFG_DOC_HEIGHT;
    cfg_ch.data  <= h;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.index <= vpr_pkg::CFG_IDX_W'($urandom_range((1 << vpr_pkg::CFG_IDX_W) - 1,
                                                       vpr_pkg::CFG_DOC_HEIGHT + 1));
    cfg_ch.data  <= vpr_pkg::DIM_W'($urandom);
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_doc_size();
    set_doc_size(vpr_pkg::DIM_W'($urandom_range(DOC_MAX, 1)),
                 vpr_pkg::DIM_W'($urandom_range(DOC_MAX, 1)));
  endtask

  // mostly well-formed subpaths, with fill rules, stray records and noise
  task automatic stream_phase(input int unsigned n_items);
    int unsigned               sent;
    int unsigned               pick;
    int unsigned               count;
    int unsigned               knots;
    logic                      closed;
    logic                      smooth;
    logic [vpr_pkg::OP_W-1:0]  op;
    logic [vpr_pkg::SEL_W-1:0] sel;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 66) begin
        closed = 1'($urandom_range(1));
        count = $urandom_range(4);
        knots = count;
        if ($urandom_range(99) < 15)
          knots = (count > 0 && $urandom_range(1)) ? count - 1 : count + 1;
        if ($urandom_range(99) < 12) op = vpr_pkg::OP_W'($urandom);
        else op = known_op();
        send_item(length_item(closed ? vpr_pkg::SEL_CLOSED_LEN : vpr_pkg::SEL_OPEN_LEN,
                              vpr_pkg::DECL_W'(count), op));
        repeat (knots) begin
          smooth = 1'($urandom_range(1));
          if (closed) sel = smooth ? vpr_pkg::SEL_CLOSED_SMOOTH : vpr_pkg::SEL_CLOSED_CORNER;
          else sel = smooth ? vpr_pkg::SEL_OPEN_SMOOTH : vpr_pkg::SEL_OPEN_CORNER;
          send_item(record_item(sel));
        end
        sent += 1 + knots;
      end else begin
        if (pick < 74) begin
          sel = $urandom_range(1) ? vpr_pkg::SEL_PATH_FILL : vpr_pkg::SEL_INIT_FILL;
          send_item(record_item(sel));
        end else if (pick < 79) begin
          send_item(record_item(vpr_pkg::SEL_CLIPBOARD));
        end else if (pick < 85) begin
          if ($urandom_range(3) == 0)
            sel = vpr_pkg::SEL_W'($urandom_range((1 << vpr_pkg::SEL_W) - 1,
                                                 vpr_pkg::SEL_INIT_FILL + 1));
          else
            sel = vpr_pkg::SEL_W'($urandom_range(15, vpr_pkg::SEL_INIT_FILL + 1));
          send_item(record_item(sel));
        end else if (pick < 91) begin
          send_item(block_end_item());
        end else begin
          if ($urandom_range(3) == 0) sel = vpr_pkg::SEL_W'($urandom);
          else sel = vpr_pkg::SEL_W'($urandom_range(15));
          send_item(record_item(sel));
        end
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    rst_ni            <= 1'b0;
    rec_ch.valid      <= 1'b0;
    rec_ch.opcode     <= OPC_RECORD;
    rec_ch.selector   <= '0;
    rec_ch.word_in_y  <= '0;
    rec_ch.word_in_x  <= '0;
    rec_ch.word_pt_y  <= '0;
    rec_ch.word_pt_x  <= '0;
    rec_ch.word_out_y <= '0;
    rec_ch.word_out_x <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= vpr_pkg::CFG_DOC_WIDTH;
    cfg_ch.data       <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset sizes: implicit subpath, flushed by a fill rule with a count mismatch
    send_item(flat_knot(vpr_pkg::SEL_CLOSED_SMOOTH, {1'b0, {(vpr_pkg::WORD_W-1){1'b1}}}));
    send_item(record_item(vpr_pkg::SEL_PATH_FILL));
    drain_results();
    set_doc_size(vpr_pkg::DIM_W'(DOC_MAX), vpr_pkg::DIM_W'(DOC_MAX));

    send_item(length_item(vpr_pkg::SEL_CLOSED_LEN, vpr_pkg::DECL_W'(2), vpr_pkg::OP_W'(0)));
    send_item(flat_knot(vpr_pkg::SEL_CLOSED_SMOOTH, {1'b1, {(vpr_pkg::WORD_W-1){1'b0}}}));
    send_item(flat_knot(vpr_pkg::SEL_CLOSED_CORNER, {1'b0, {(vpr_pkg::WORD_W-1){1'b1}}}));
    send_item(length_item(vpr_pkg::SEL_OPEN_LEN, vpr_pkg::DECL_W'(1), vpr_pkg::OP_MINUS_ONE));
    send_item(record_item(vpr_pkg::SEL_OPEN_SMOOTH));
    send_item(record_item(vpr_pkg::SEL_OPEN_CORNER));
    send_item(length_item(vpr_pkg::SEL_CLOSED_LEN, vpr_pkg::DECL_W'(0),
                          vpr_pkg::OP_MAX_KNOWN + 1'b1));
    send_item(length_item(vpr_pkg::SEL_OPEN_LEN, '1, {1'b1, {(vpr_pkg::OP_W-1){1'b0}}}));
    send_item(record_item(vpr_pkg::SEL_INIT_FILL));
    send_item(record_item(vpr_pkg::SEL_INIT_FILL));
    send_item(record_item(vpr_pkg::SEL_CLIPBOARD));
    send_item(length_item(vpr_pkg::SEL_CLOSED_LEN, vpr_pkg::DECL_W'(1), vpr_pkg::OP_W'(1)));
    send_item(record_item(vpr_pkg::SEL_CLOSED_CORNER));
    send_item(record_item(vpr_pkg::SEL_CLIPBOARD));
    send_item(length_item(vpr_pkg::SEL_OPEN_LEN, vpr_pkg::DECL_W'(0), vpr_pkg::OP_W'(2)));
    send_item(record_item(vpr_pkg::SEL_INIT_FILL + 1'b1));
    send_item(record_item('1));
    send_item(flat_knot(vpr_pkg::SEL_OPEN_CORNER, '0));
    send_item(length_item(vpr_pkg::SEL_CLOSED_LEN, vpr_pkg::DECL_W'(1), vpr_pkg::OP_MAX_KNOWN));
    send_item(flat_knot(vpr_pkg::SEL_CLOSED_SMOOTH, '1));
    send_item(block_end_item());
    send_item(block_end_item());
    drain_results();

    random_doc_size();
    stream_phase(PHASE_ITEMS);
    drain_results();

    // no idling at all, and the result side holds off while records keep coming
    set_doc_size(vpr_pkg::DIM_W'(DOC_MAX), vpr_pkg::DIM_W'(DOC_MAX));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req = 1'b1;
    stream_phase(PHASE_ITEMS);
    drain_results();
    send_idle_pct = IDLE_PCT;
    recv_idle_pct = IDLE_PCT;

    set_doc_size(vpr_pkg::DIM_W'(1), vpr_pkg::DIM_W'(DOC_MAX));
    stream_phase(PHASE_ITEMS / 2);
    drain_results();
    stream_phase(PHASE_ITEMS / 2);
    drain_results();

    set_doc_size(vpr_pkg::DIM_W'(DOC_MAX), vpr_pkg::DIM_W'(1));
    stream_phase(PHASE_ITEMS);
    drain_results();

    repeat (2) begin
      random_doc_size();
      stream_phase(PHASE_ITEMS);
      drain_results();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_vector_path_record_decoder_unit: done, clean");
    end else begin
      $display("tb_vector_path_record_decoder_unit: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/vpr_pkg.sv
hdl/vpr_rec_if.sv
hdl/vpr_res_if.sv
hdl/vpr_cfg_if.sv
hdl/vector_path_record_decoder_unit.sv
hdl/vpr_checker.sv
tb/sv/tb_vpr_decode_checker.sv
tb/sv/tb_vector_path_record_decoder_unit.sv
